>>> rtl/core/upp_pkg.sv
// Package for the unwrapped position PID unit.
// Holds fixed constants, register and drive codes, and the tracker result type.
// No dependencies.
`default_nettype none

package upp_pkg;

  localparam int DATA_W = 16;

  localparam logic [DATA_W-1:0]        FLIP_LIMIT     = 16'd600;
  localparam logic [DATA_W-1:0]        FLIP_STEP      = 16'd700;
  localparam logic signed [DATA_W-1:0] INTEGRAL_LIMIT = 16'sd700;
  localparam logic signed [DATA_W-1:0] WALL_HIGH      = 16'sd1200;
  localparam logic signed [DATA_W-1:0] WALL_LOW       = -16'sd1200;
  localparam logic [DATA_W-1:0]        GAIN_P_RESET   = 16'd17;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WALL   = 3'd4;

  localparam logic [1:0] DRIVE_ZERO = 2'd0;
  localparam logic [1:0] DRIVE_NEG  = 2'd1;
  localparam logic [1:0] DRIVE_POS  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic                     clockwise;
    logic                     flip;
  } unwrap_t;

endpackage

`default_nettype wire

>>> rtl/core/upp_if.sv
// Stream interfaces for the unwrapped position PID unit: sample beats in,
// result beats out. Depends on upp_pkg for the data width.
`default_nettype none

interface upp_sample_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sensor_sample;

  modport source (output valid, output sensor_sample, input ready);
  modport sink   (input valid, input sensor_sample, output ready);
  modport mon    (input valid, input sensor_sample, input ready);
endinterface

interface upp_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [upp_pkg::DATA_W-1:0] duty;
  logic [1:0]                       drive_sign;
  logic signed [upp_pkg::DATA_W-1:0] position;
  logic                             turning_clockwise;
  logic                             flip_seen;

  modport source (output valid, output duty, output drive_sign, output position,
                  output turning_clockwise, output flip_seen, input ready);
  modport sink   (input valid, input duty, input drive_sign, input position,
                  input turning_clockwise, input flip_seen, output ready);
  modport mon    (input valid, input duty, input drive_sign, input position,
                  input turning_clockwise, input flip_seen, input ready);
endinterface

`default_nettype wire

>>> rtl/core/upp_unwrap.sv
// Wrap tracker: sample history, flip detection and unwrapped position stage.
// Depends on upp_pkg.
`default_nettype none

module upp_unwrap #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [SAMPLE_BITS-1:0] target,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output upp_pkg::unwrap_t            track
);

  logic [SAMPLE_BITS-1:0]        previous_sample;
  logic [SAMPLE_BITS-1:0]        older_sample;
  logic [upp_pkg::DATA_W-1:0]    flip_offset;
  logic                          flip_latched;

  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          mag;
  logic                          flip_now;
  logic [upp_pkg::DATA_W-1:0]    flip_offset_next;
  logic [upp_pkg::DATA_W-1:0]    position;

  always_comb begin
    diff = $signed({1'b0, sample}) - $signed({1'b0, older_sample});
    mag  = diff[SAMPLE_BITS] ? -diff : diff;
    flip_now = (upp_pkg::DATA_W'(mag) > upp_pkg::FLIP_LIMIT) && !flip_latched;
    if (!flip_now) begin
      flip_offset_next = flip_offset;
    end else if (diff[SAMPLE_BITS]) begin
      flip_offset_next = flip_offset + upp_pkg::FLIP_STEP;
    end else begin
      flip_offset_next = flip_offset - upp_pkg::FLIP_STEP;
    end
    position = upp_pkg::DATA_W'(sample) + flip_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      older_sample    <= '0;
      flip_offset     <= '0;
      flip_latched    <= 1'b0;
    end else if (load) begin
      previous_sample <= target;
      older_sample    <= target;
    end else if (step) begin
      older_sample    <= previous_sample;
      previous_sample <= sample;
      flip_offset     <= flip_offset_next;
      flip_latched    <= flip_now;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      track.position  <= $signed(position);
      track.clockwise <= !diff[SAMPLE_BITS];
      track.flip      <= flip_now;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/unwrapped_position_pid_unit.sv
// Unwrapped position PID unit: angle sample tracking, PID and wall gating.
// Depends on upp_pkg, upp_if (upp_sample_if, upp_result_if) and upp_unwrap.
//
// Takes one sensor sample beat per clock and returns one result beat per
// sample. Five register stages (input, unwrap, error/integral, gain products,
// output) lie between an accepted sample and its result; throughput is one
// sample per cycle while results are taken, and a stalled result holds every
// occupied stage behind it. The wrap counter, integral and previous position
// are held in the unwrap and error stages, each updated once per sample as it
// passes. Configuration goes through the APB port; the user must write it only
// while the unit is idle, as the unit does not enforce this. Writing
// target_position also presets the sample history and the previous position.
`default_nettype none

module unwrapped_position_pid_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  upp_sample_if.sink       samples,
  upp_result_if.source     results
);

  localparam int DW = upp_pkg::DATA_W;

  logic [SAMPLE_BITS-1:0] target_position;
  logic [DW-1:0]          gain_p;
  logic [DW-1:0]          gain_i;
  logic [DW-1:0]          gain_d;
  logic                   wall_enable;

  logic                   cfg_write;
  logic [upp_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                   target_load;

  logic v0, v1, v2, v3, v4;
  logic take1, take2, take3, take4;
  logic move0, move1;

  logic [SAMPLE_BITS-1:0] s0_sample;
  upp_pkg::unwrap_t       track;

  logic [DW-1:0]          error_integral;
  logic [DW-1:0]          last_position;
  logic [DW-1:0]          err;
  logic signed [DW-1:0]   serr;
  logic [DW-1:0]          error_integral_next;

  logic [DW-1:0]          b_err;
  logic [DW-1:0]          b_integ;
  logic [DW-1:0]          b_dpos;
  logic signed [DW-1:0]   b_pos;
  logic                   b_cw;
  logic                   b_flip;

  logic [2*DW-1:0]        p_full;
  logic [2*DW-1:0]        i_full;
  logic [2*DW-1:0]        d_full;

  logic [DW-1:0]          c_p;
  logic [DW-1:0]          c_i;
  logic [DW-1:0]          c_d;
  logic signed [DW-1:0]   c_pos;
  logic                   c_cw;
  logic                   c_flip;

  logic [DW-1:0]          sum;
  logic signed [DW-1:0]   duty_next;
  logic [1:0]             sign_next;

  // configuration port
  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign cfg_idx     = paddr[4:2];
  assign target_load = cfg_write && (cfg_idx == upp_pkg::REG_TARGET);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      gain_p          <= upp_pkg::GAIN_P_RESET;
      gain_i          <= '0;
      gain_d          <= '0;
      wall_enable     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        upp_pkg::REG_TARGET: target_position <= pwdata[SAMPLE_BITS-1:0];
        upp_pkg::REG_GAIN_P: gain_p          <= pwdata[DW-1:0];
        upp_pkg::REG_GAIN_I: gain_i          <= pwdata[DW-1:0];
        upp_pkg::REG_GAIN_D: gain_d          <= pwdata[DW-1:0];
        upp_pkg::REG_WALL:   wall_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      upp_pkg::REG_TARGET: prdata = 32'(target_position);
      upp_pkg::REG_GAIN_P: prdata = 32'(gain_p);
      upp_pkg::REG_GAIN_I: prdata = 32'(gain_i);
      upp_pkg::REG_GAIN_D: prdata = 32'(gain_d);
      upp_pkg::REG_WALL:   prdata = 32'(wall_enable);
      default:             prdata = '0;
    endcase
  end

  // pipeline flow control
  assign take4         = !v4 || results.ready;
  assign take3         = !v3 || take4;
  assign take2         = !v2 || take3;
  assign take1         = !v1 || take2;
  assign samples.ready = !v0 || take1;
  assign move0         = v0 && take1;
  assign move1         = v1 && take2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (samples.ready) v0 <= samples.valid;
      if (take1)         v1 <= v0;
      if (take2)         v2 <= v1;
      if (take3)         v3 <= v2;
      if (take4)         v4 <= v3;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (samples.ready) begin
      s0_sample <= samples.sensor_sample;
    end
  end

  // unwrap stage
  upp_unwrap #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_unwrap (
    .clk    (clk),
    .rst    (rst),
    .load   (target_load),
    .target (pwdata[SAMPLE_BITS-1:0]),
    .step   (move0),
    .sample (s0_sample),
    .track  (track)
  );

  // error and integral stage
  always_comb begin
    err  = DW'(target_position) - track.position;
    serr = $signed(err);
    if ((serr < upp_pkg::INTEGRAL_LIMIT) && (serr > -upp_pkg::INTEGRAL_LIMIT)) begin
      error_integral_next = error_integral + err;
    end else begin
      error_integral_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      last_position  <= '0;
    end else if (target_load) begin
      last_position  <= DW'(pwdata[SAMPLE_BITS-1:0]);
    end else if (move1) begin
      error_integral <= error_integral_next;
      last_position  <= track.position;
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      b_err   <= err;
      b_integ <= error_integral_next;
      b_dpos  <= last_position - track.position;
      b_pos   <= track.position;
      b_cw    <= track.clockwise;
      b_flip  <= track.flip;
    end
  end

  // gain product stage
  assign p_full = b_err * gain_p;
  assign i_full = b_integ * gain_i;
  assign d_full = b_dpos * gain_d;

  always_ff @(posedge clk) begin
    if (take3) begin
      c_p    <= p_full[DW-1:0];
      c_i    <= i_full[DW-1:0];
      c_d    <= d_full[DW-1:0];
      c_pos  <= b_pos;
      c_cw   <= b_cw;
      c_flip <= b_flip;
    end
  end

  // sum, wall gate and output stage
  always_comb begin
    sum = c_p + c_i + c_d;
    if (wall_enable && (c_pos != upp_pkg::WALL_HIGH) && (c_pos != upp_pkg::WALL_LOW)) begin
      duty_next = '0;
    end else begin
      duty_next = $signed(sum);
    end
    priority if (duty_next == '0) begin
      sign_next = upp_pkg::DRIVE_ZERO;
    end else if (duty_next[DW-1]) begin
      sign_next = upp_pkg::DRIVE_NEG;
    end else begin
      sign_next = upp_pkg::DRIVE_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (take4) begin
      results.duty              <= duty_next;
      results.drive_sign        <= sign_next;
      results.position          <= c_pos;
      results.turning_clockwise <= c_cw;
      results.flip_seen         <= c_flip;
    end
  end

  assign results.valid = v4;

endmodule

`default_nettype wire

>>> rtl/core/upp_checker.sv
// Port-level checker for the unwrapped position PID unit, bound to the top.
// Depends on upp_if (upp_sample_if sink and upp_result_if source modports).
`default_nettype none

module upp_checker (
  input wire logic     clk,
  input wire logic     rst,
  upp_sample_if.sink   samples,
  upp_result_if.source results
);

  logic       in_beat;
  logic       out_beat;
  logic [3:0] outstanding;
  logic       last_flip;

  assign in_beat  = samples.valid && samples.ready;
  assign out_beat = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_flip   <= 1'b0;
    end else begin
      outstanding <= outstanding + 4'(in_beat) - 4'(out_beat);
      if (out_beat) last_flip <= results.flip_seen;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid && $stable(results.duty)
      && $stable(results.position))
    else $error("result beat dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> outstanding != 4'd0)
    else $error("result beat without an accepted sample");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'd5)
    else $error("more samples in flight than pipeline stages");

  a_no_double_flip: assert property (@(posedge clk) disable iff (rst)
    out_beat && results.flip_seen |-> !last_flip)
    else $error("flip counted on two consecutive samples");

endmodule

bind unwrapped_position_pid_unit upp_checker u_upp_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples),
  .results (results)
);

`default_nettype wire
